>>> hw/rtl/acc_pkg.sv
package acc_pkg;

   localparam int HIST_DEPTH = 4;
   localparam int SAMPLE_W   = 10;
   localparam int AVG_W      = 18;
   localparam int MODE_W     = 4;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int REQ_DW     = 16;
   localparam int RSP_DW     = 80;

   localparam logic [AVG_W-1:0]  AVG_MAX   = 18'd261888;
   localparam logic [MODE_W-1:0] MODE_BASE = 4'd5;
   localparam logic [MODE_W-1:0] MODE_STEP = 4'd2;

   localparam logic [2:0] REG_RANGE_SELECT = 3'd0;
   localparam logic [2:0] REG_DETECT_EN    = 3'd1;
   localparam logic [2:0] REG_THRESHOLD    = 3'd2;
   localparam logic [2:0] REG_HOLD_LENGTH  = 3'd3;
   localparam logic [2:0] REG_WIN_A_FIRST  = 3'd4;
   localparam logic [2:0] REG_WIN_A_SECOND = 3'd5;
   localparam logic [2:0] REG_WIN_B_FIRST  = 3'd6;
   localparam logic [2:0] REG_WIN_B_SECOND = 3'd7;

   localparam logic [1:0] RANGE_WIDE = 2'd0;
   localparam logic [1:0] RANGE_MID  = 2'd1;

   typedef struct packed {
      logic [1:0]       range_select;
      logic             detect_enable;
      logic [10:0]      activity_threshold;
      logic [15:0]      hold_length;
      logic [3:0][5:0]  win_len;
   } cfg_type;

   typedef struct packed {
      logic       latch;
      logic       hist_wr;
      logic       hist_rd;
      logic [1:0] rd_idx;
      logic       cap;
      logic [1:0] cap_idx;
      logic       calc;
      logic       scale;
      logic       win_rd;
      logic       win_upd;
      logic       win_wr2;
      logic       div_start;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic low_ch;
      logic hit;
      logic div_done;
      logic out_free;
   } sts_type;

   function automatic logic [10:0] range_factor(input logic [1:0] sel);
      logic [10:0] f;
      case (sel)
         RANGE_WIDE: f = 11'd2047;
         RANGE_MID:  f = 11'd1551;
         default:    f = 11'd1023;
      endcase
      return f;
   endfunction

endpackage

>>> hw/rtl/adc_channel_conditioner_core.sv
// ADC channel conditioner core.
// req channel: one beat per converter sample, channels scanned 0 upwards per
//   tick. tdata = {sample[12:3], channel[2:0]}.
// rsp channel: one beat per request beat, in order, carrying channel, 4-deep
//   mean, range-scaled mean, activity, hit flag, both pair averages and mode.
// csr: register i at byte address 4*i; the user must write only while the core is idle, the core does not enforce this.
// Timing: one request in flight. Channels 0-3 go through the history write,
//   history reads, calc and scale, on a hit the window read and both window
//   writes, then the two bit-serial dividers that form the window averages;
//   other channels go to the output after scale, out-of-range channels after
//   the history write. The next request is taken in the cycle after the result
//   is loaded. History reads use a single memory port, four reads per beat.
// A finished beat sits in the output register; the next request is taken
//   meanwhile, and its result waits while rsp_tready is low.
// Reset clears histories, windows, holds and registers to their defaults;
//   no clearing pass is needed, beats are accepted straight after.
module adc_channel_conditioner_core #(
   parameter int CHANNELS   = 8,
   parameter int MAX_WINDOW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [acc_pkg::REQ_DW-1:0]    req_tdata,  // channel[2:0], sample[12:3]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // channel_out[2:0], smoothed[12:3], scaled[23:13], activity[35:24],
   // activity_hit[36], first_average[54:37], second_average[72:55], mode_code[76:73]
   output logic [acc_pkg::RSP_DW-1:0]    rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [acc_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [acc_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [acc_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import acc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   acc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   acc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   acc_dp #(.CHANNELS(CHANNELS), .MAX_WINDOW(MAX_WINDOW)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .in_data   (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

>>> hw/rtl/acc_csr.sv
module acc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [acc_pkg::CSR_AW-1:0]    paddr,
   input  logic [acc_pkg::CSR_DW-1:0]    pwdata,
   output logic [acc_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output acc_pkg::cfg_type              cfg
);
   import acc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_AW-1:2];
   assign wr     = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_RANGE_SELECT: cfg_in.range_select       = pwdata[1:0];
            REG_DETECT_EN:    cfg_in.detect_enable      = pwdata[0];
            REG_THRESHOLD:    cfg_in.activity_threshold = pwdata[10:0];
            REG_HOLD_LENGTH:  cfg_in.hold_length        = pwdata[15:0];
            REG_WIN_A_FIRST:  cfg_in.win_len[0]         = pwdata[5:0];
            REG_WIN_A_SECOND: cfg_in.win_len[1]         = pwdata[5:0];
            REG_WIN_B_FIRST:  cfg_in.win_len[2]         = pwdata[5:0];
            REG_WIN_B_SECOND: cfg_in.win_len[3]         = pwdata[5:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_RANGE_SELECT: prdata = {30'd0, cfg_ff.range_select};
         REG_DETECT_EN:    prdata = {31'd0, cfg_ff.detect_enable};
         REG_THRESHOLD:    prdata = {21'd0, cfg_ff.activity_threshold};
         REG_HOLD_LENGTH:  prdata = {16'd0, cfg_ff.hold_length};
         REG_WIN_A_FIRST:  prdata = {26'd0, cfg_ff.win_len[0]};
         REG_WIN_A_SECOND: prdata = {26'd0, cfg_ff.win_len[1]};
         REG_WIN_B_FIRST:  prdata = {26'd0, cfg_ff.win_len[2]};
         REG_WIN_B_SECOND: prdata = {26'd0, cfg_ff.win_len[3]};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_select       <= 2'd0;
         cfg_ff.detect_enable      <= 1'b0;
         cfg_ff.activity_threshold <= 11'd160;
         cfg_ff.hold_length        <= 16'd1000;
         cfg_ff.win_len[0]         <= 6'd8;
         cfg_ff.win_len[1]         <= 6'd16;
         cfg_ff.win_len[2]         <= 6'd8;
         cfg_ff.win_len[3]         <= 6'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/acc_div.sv
module acc_div #(
   parameter int DIVIDEND_W = 23,
   parameter int DIVISOR_W  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);
   import acc_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  ge;

   assign trial    = {rem_ff, q_ff[DIVIDEND_W-1]};
   assign ge       = trial >= {1'b0, dvs_ff};
   assign quotient = q_ff;
   assign done     = done_ff;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in    = {q_ff[DIVIDEND_W-2:0], ge};
         rem_in  = ge ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) dvs_ff <= divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

>>> hw/rtl/acc_ctrl.sv
module acc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  acc_pkg::sts_type sts,
   output acc_pkg::cmd_type cmd
);
   import acc_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_HWR   = 11'b00000000010,
      ST_HRD   = 11'b00000000100,
      ST_CALC  = 11'b00000001000,
      ST_SCALE = 11'b00000010000,
      ST_WRD   = 11'b00000100000,
      ST_WUPD  = 11'b00001000000,
      ST_WWR2  = 11'b00010000000,
      ST_DIVS  = 11'b00100000000,
      ST_DIVW  = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = in_valid;
            if (in_valid) state_in = ST_HWR;
         end
         ST_HWR: begin
            cmd.hist_wr = 1'b1;
            cnt_in      = 3'd0;
            state_in    = sts.in_range ? ST_HRD : ST_OUT;
         end
         ST_HRD: begin
            cmd.hist_rd = (cnt_ff != 3'd4);
            cmd.rd_idx  = cnt_ff[1:0];
            cmd.cap     = (cnt_ff != 3'd0);
            cmd.cap_idx = cnt_ff[1:0] - 2'd1;
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            if (sts.hit)         state_in = ST_WRD;
            else if (sts.low_ch) state_in = ST_DIVS;
            else                 state_in = ST_OUT;
         end
         ST_WRD: begin
            cmd.win_rd = 1'b1;
            state_in   = ST_WUPD;
         end
         ST_WUPD: begin
            cmd.win_upd = 1'b1;
            state_in    = ST_WWR2;
         end
         ST_WWR2: begin
            cmd.win_wr2 = 1'b1;
            state_in    = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.out_load = sts.out_free;
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/acc_dp.sv
module acc_dp #(
   parameter int CHANNELS   = 8,
   parameter int MAX_WINDOW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  acc_pkg::cfg_type              cfg,
   input  acc_pkg::cmd_type              cmd,
   output acc_pkg::sts_type              sts,
   input  logic [acc_pkg::REQ_DW-1:0]    in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [acc_pkg::RSP_DW-1:0]    out_data
);
   import acc_pkg::*;

   localparam int HIST_N  = CHANNELS * HIST_DEPTH;
   localparam int HA_W    = $clog2(HIST_N);
   localparam int HA_CH_W = HA_W - 2;
   localparam int WS_N    = 4 * MAX_WINDOW;
   localparam int WA_W    = $clog2(WS_N);
   localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int N_W     = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W   = $clog2(MAX_WINDOW * 1023 + 1);
   localparam int D_W     = SUM_W + 8;

   function automatic logic [N_W-1:0] eff_window(input logic [5:0] len);
      logic [N_W-1:0] n;
      if (len == 6'd0)                 n = N_W'(1);
      else if (32'(len) > MAX_WINDOW)  n = N_W'(MAX_WINDOW);
      else                             n = N_W'(len);
      return n;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s,
                                                   input logic [N_W-1:0] n);
      logic [N_W:0] s1;
      s1 = (N_W+1)'(s) + 1'b1;
      return (s1 >= {1'b0, n}) ? '0 : SLOT_W'(s1);
   endfunction

   function automatic logic [AVG_W-1:0] sat_avg(input logic [D_W-1:0] q);
      return (32'(q) > 32'(AVG_MAX)) ? AVG_MAX : AVG_W'(q);
   endfunction

   logic [2:0]          ch_ff;
   logic [9:0]          sample_ff;
   logic                in_range, low_ch, last_ch, p;

   logic [9:0]          hist_mem [HIST_N];
   logic [HIST_N-1:0]   hist_vld_ff;
   logic [9:0]          hist_rd_ff;
   logic                hist_rv_ff;
   logic [HA_W-1:0]     hist_wa, hist_ra;
   logic [9:0]          hr_ff [HIST_DEPTH];
   logic [1:0]          hslot_ff;

   logic [9:0]          smooth_ff;
   logic [10:0]         scaled_ff;
   logic [11:0]         act_ff;
   logic                hit_ff;
   logic [11:0]         sum4;
   logic signed [12:0]  act13, thr13;
   logic [20:0]         prod;

   logic [9:0]          ws_mem [WS_N];
   logic [WS_N-1:0]     ws_vld_ff;
   logic [9:0]          wrf_ff, wrs_ff;
   logic                wvf_ff, wvs_ff;
   logic [SUM_W-1:0]    sumf_ff [2];
   logic [SUM_W-1:0]    sums_ff [2];
   logic [SLOT_W-1:0]   slotf_ff [2];
   logic [SLOT_W-1:0]   slots_ff [2];
   logic [N_W-1:0]      nf, ns;
   logic [WA_W-1:0]     addr_f, addr_s;
   logic [9:0]          old_f, old_s;

   logic [15:0]         hold_ff [2];
   logic [MODE_W-1:0]   mode_ff;
   logic                nz0, nz1;

   logic [D_W-1:0]      qf, qs;
   logic                donef, dones;

   logic                rv_ff;
   logic [RSP_DW-1:0]   rd_ff;

   assign in_range = 32'(ch_ff) < CHANNELS;
   assign low_ch   = in_range && (ch_ff < 3'd4);
   assign last_ch  = 32'(ch_ff) == (CHANNELS - 1);
   assign p        = ch_ff[0];

   assign sts.in_range = in_range;
   assign sts.low_ch   = low_ch;
   assign sts.hit      = hit_ff;
   assign sts.div_done = donef & dones;
   assign sts.out_free = !rv_ff || out_ready;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ch_ff     <= in_data[2:0];
         sample_ff <= in_data[12:3];
      end
   end

   // history: newest slot first, so hr holds h[s], h[s-1], h[s-2], h[s-3]
   assign hist_wa = {HA_CH_W'(ch_ff), hslot_ff};
   assign hist_ra = {HA_CH_W'(ch_ff), hslot_ff - cmd.rd_idx};

   always_ff @(posedge clock) begin
      if (cmd.hist_wr && in_range) hist_mem[hist_wa] <= sample_ff;
      if (cmd.hist_rd) begin
         hist_rd_ff <= hist_mem[hist_ra];
         hist_rv_ff <= hist_vld_ff[hist_ra];
      end
      if (cmd.cap) hr_ff[cmd.cap_idx] <= hist_rv_ff ? hist_rd_ff : 10'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) hist_vld_ff <= '0;
      else if (cmd.hist_wr && in_range) hist_vld_ff[hist_wa] <= 1'b1;
   end

   assign sum4  = 12'(hr_ff[0]) + 12'(hr_ff[1]) + 12'(hr_ff[2]) + 12'(hr_ff[3]);
   assign act13 = $signed({3'b0, hr_ff[0]}) - $signed({3'b0, hr_ff[1]})
                + $signed({3'b0, hr_ff[2]}) - $signed({3'b0, hr_ff[3]});
   assign thr13 = $signed({2'b0, cfg.activity_threshold});
   assign prod  = smooth_ff * range_factor(cfg.range_select);

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         smooth_ff <= sum4[11:2];
         act_ff    <= act13[11:0];
      end
      if (cmd.scale) scaled_ff <= prod[20:10];
   end

   always_ff @(posedge clock) begin
      if (reset) hit_ff <= 1'b0;
      else if (cmd.calc)
         hit_ff <= low_ch && cfg.detect_enable && (act13 > thr13 || act13 < -thr13);
   end

   // moving-average windows of the pair
   assign nf     = eff_window(p ? cfg.win_len[2] : cfg.win_len[0]);
   assign ns     = eff_window(p ? cfg.win_len[3] : cfg.win_len[1]);
   assign addr_f = WA_W'((p ? 2 : 0) * MAX_WINDOW) + WA_W'(slotf_ff[p]);
   assign addr_s = WA_W'((p ? 3 : 1) * MAX_WINDOW) + WA_W'(slots_ff[p]);
   assign old_f  = wvf_ff ? wrf_ff : 10'd0;
   assign old_s  = wvs_ff ? wrs_ff : 10'd0;

   always_ff @(posedge clock) begin
      if (cmd.win_rd) begin
         wrf_ff <= ws_mem[addr_f];
         wrs_ff <= ws_mem[addr_s];
         wvf_ff <= ws_vld_ff[addr_f];
         wvs_ff <= ws_vld_ff[addr_s];
      end
      if (cmd.win_upd)      ws_mem[addr_f] <= sample_ff;
      else if (cmd.win_wr2) ws_mem[addr_s] <= sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_vld_ff   <= '0;
         sumf_ff[0]  <= '0;
         sumf_ff[1]  <= '0;
         sums_ff[0]  <= '0;
         sums_ff[1]  <= '0;
         slotf_ff[0] <= '0;
         slotf_ff[1] <= '0;
         slots_ff[0] <= '0;
         slots_ff[1] <= '0;
      end else if (cmd.win_upd) begin
         ws_vld_ff[addr_f] <= 1'b1;
         sumf_ff[p]        <= sumf_ff[p] - SUM_W'(old_f) + SUM_W'(sample_ff);
         slotf_ff[p]       <= slot_next(slotf_ff[p], nf);
      end else if (cmd.win_wr2) begin
         ws_vld_ff[addr_s] <= 1'b1;
         sums_ff[p]        <= sums_ff[p] - SUM_W'(old_s) + SUM_W'(sample_ff);
         slots_ff[p]       <= slot_next(slots_ff[p], ns);
      end
   end

   acc_div #(.DIVIDEND_W(D_W), .DIVISOR_W(N_W)) u_div_first (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({sumf_ff[p], 8'd0}),
      .divisor  (nf),
      .quotient (qf),
      .done     (donef)
   );

   acc_div #(.DIVIDEND_W(D_W), .DIVISOR_W(N_W)) u_div_second (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({sums_ff[p], 8'd0}),
      .divisor  (ns),
      .quotient (qs),
      .done     (dones)
   );

   // holds, mode and tick bookkeeping
   assign nz0 = p ? (hold_ff[0] != 16'd0) : (cfg.hold_length != 16'd0);
   assign nz1 = p ? (cfg.hold_length != 16'd0) : (hold_ff[1] != 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff[0] <= 16'd0;
         hold_ff[1] <= 16'd0;
         mode_ff    <= MODE_BASE;
         hslot_ff   <= 2'd0;
      end else begin
         if (cmd.hist_wr && in_range && ch_ff == 3'd0) mode_ff <= MODE_BASE;
         if (cmd.scale && hit_ff) begin
            hold_ff[p] <= cfg.hold_length;
            mode_ff    <= MODE_BASE + MODE_STEP * (MODE_W'(nz0) + MODE_W'(nz1));
         end
         if (cmd.out_load && in_range && last_ch) begin
            if (hold_ff[0] != 16'd0) hold_ff[0] <= hold_ff[0] - 16'd1;
            if (hold_ff[1] != 16'd0) hold_ff[1] <= hold_ff[1] - 16'd1;
            hslot_ff <= hslot_ff + 2'd1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= cmd.out_load || (rv_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load)
         rd_ff <= {3'd0,
                   mode_ff,
                   low_ch ? sat_avg(qs) : 18'd0,
                   low_ch ? sat_avg(qf) : 18'd0,
                   low_ch ? hit_ff : 1'b0,
                   low_ch ? act_ff : 12'd0,
                   in_range ? scaled_ff : 11'd0,
                   in_range ? smooth_ff : 10'd0,
                   ch_ff};
   end

   assign out_valid = rv_ff;
   assign out_data  = rd_ff;

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff == 4'd5 || mode_ff == 4'd7 || mode_ff == 4'd9)
      else $error("mode code out of range");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      32'(slotf_ff[0]) < MAX_WINDOW && 32'(slots_ff[1]) < MAX_WINDOW)
      else $error("window slot past store");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rv_ff || out_ready))
      else $error("result overwritten while stalled");

   a_hit_low: assert property (@(posedge clock) disable iff (reset)
      cmd.win_upd |-> low_ch && hit_ff)
      else $error("window update without hit");

endmodule
